FILE: rtl/cst_pkg.sv
// Shared types and codes for the sparse matrix transpose block.
package cst_pkg;

	localparam int ROW_W = 8;
	localparam int COL_W = 8;
	localparam int VAL_W = 32;
	localparam int IDX_W = 11;
	localparam int PTR_W = 11;
	localparam int NCOL_W = 9;
	localparam int STATUS_W = 3;

	localparam logic [1:0] FUNC_LOAD = 2'd0;
	localparam logic [1:0] FUNC_BUILD = 2'd1;
	localparam logic [1:0] FUNC_RDPTR = 2'd2;
	localparam logic [1:0] FUNC_RDENT = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 3'd1;
	localparam logic [STATUS_W-1:0] ST_COL = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ROW = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD = 3'd4;

	typedef struct packed {
		logic [1:0] func;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic signed [VAL_W-1:0] value;
		logic [IDX_W-1:0] read_index;
	} in_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [PTR_W-1:0] out_pointer;
		logic [ROW_W-1:0] out_index;
		logic signed [VAL_W-1:0] out_value;
	} out_t;

	typedef struct packed {
		logic capture;
		logic dec;
		logic ldinc;
		logic bcnt;
		logic bacc;
		logic ssrc;
		logic sfil;
		logic swr;
		logic bfin;
		logic resp;
	} cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic dec_err;
		logic nc_zero;
		logic ec_zero;
		logic last_col;
		logic last_ent;
		logic col_ok;
		logic out_free;
	} sts_t;

endpackage

FILE: rtl/csr_sparse_transpose.sv
// Top level of the compressed-row sparse matrix transpose block.
// One command at a time; a load passes through decode, count update and the result
// register, a read or a rejected load through decode and the result register.
// A build runs count read and accumulate per column for the pointer running sum,
// then source read, fill read and, for a column in range, a write per stored entry.
// Reset (arst_n low) empties the counts and the built state; columns return to 256.
module csr_sparse_transpose #(
	parameter int MAX_NONZEROS = 1024,
	parameter int MAX_DIM = 256
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input cst_pkg::in_t req,
	output logic rsp_valid,
	input logic rsp_stall,
	output cst_pkg::out_t rsp,
	input logic cfg_we,
	input logic [cst_pkg::NCOL_W-1:0] cfg_wdata
);

	cst_pkg::cmd_t cmd;
	cst_pkg::sts_t sts;

	cst_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.sts(sts), .cmd(cmd)
	);

	cst_dp #(.MAX_NONZEROS(MAX_NONZEROS), .MAX_DIM(MAX_DIM)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .req(req),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

endmodule

FILE: rtl/cst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/cst_ctrl.sv
// Sequencer for load, build and read commands of the transpose block.
module cst_ctrl (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_stall,
	input cst_pkg::sts_t sts,
	output cst_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC = 4'd1;
	localparam logic [3:0] S_LDINC = 4'd2;
	localparam logic [3:0] S_BCNT = 4'd3;
	localparam logic [3:0] S_BACC = 4'd4;
	localparam logic [3:0] S_SSRC = 4'd5;
	localparam logic [3:0] S_SFIL = 4'd6;
	localparam logic [3:0] S_SWR = 4'd7;
	localparam logic [3:0] S_BFIN = 4'd8;
	localparam logic [3:0] S_RESP = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				cmd.dec = 1'b1;
				case (sts.func)
					cst_pkg::FUNC_LOAD: state_d = sts.dec_err ? S_RESP : S_LDINC;
					cst_pkg::FUNC_BUILD: begin
						if (!sts.nc_zero) state_d = S_BCNT;
						else state_d = sts.ec_zero ? S_BFIN : S_SSRC;
					end
					default: state_d = S_RESP;
				endcase
			end
			S_LDINC: begin
				cmd.ldinc = 1'b1;
				state_d = S_RESP;
			end
			S_BCNT: begin
				cmd.bcnt = 1'b1;
				state_d = S_BACC;
			end
			S_BACC: begin
				cmd.bacc = 1'b1;
				if (!sts.last_col) state_d = S_BCNT;
				else state_d = sts.ec_zero ? S_BFIN : S_SSRC;
			end
			S_SSRC: begin
				cmd.ssrc = 1'b1;
				state_d = S_SFIL;
			end
			S_SFIL: begin
				cmd.sfil = 1'b1;
				if (sts.col_ok) state_d = S_SWR;
				else state_d = sts.last_ent ? S_BFIN : S_SSRC;
			end
			S_SWR: begin
				cmd.swr = 1'b1;
				state_d = sts.last_ent ? S_BFIN : S_SSRC;
			end
			S_BFIN: begin
				cmd.bfin = 1'b1;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.resp = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/cst_dp.sv
// Datapath: stores, counters, column counts and the result register.
module cst_dp #(
	parameter int MAX_NONZEROS = 1024,
	parameter int MAX_DIM = 256
) (
	input logic clk,
	input logic arst_n,
	input cst_pkg::cmd_t cmd,
	output cst_pkg::sts_t sts,
	input cst_pkg::in_t req,
	input logic cfg_we,
	input logic [cst_pkg::NCOL_W-1:0] cfg_wdata,
	output logic rsp_valid,
	input logic rsp_stall,
	output cst_pkg::out_t rsp
);

	localparam int AW = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1;
	localparam int CW = $clog2(MAX_NONZEROS + 1);
	localparam int DW = $clog2(MAX_DIM + 1);
	localparam int CAW = $clog2(MAX_DIM);
	localparam int SRC_W = cst_pkg::ROW_W + cst_pkg::COL_W + cst_pkg::VAL_W;
	localparam int DST_W = cst_pkg::ROW_W + cst_pkg::VAL_W;

	cst_pkg::in_t in_q;
	cst_pkg::out_t res_q;
	cst_pkg::out_t out_q;
	cst_pkg::out_t res_d;
	cst_pkg::out_t out_d;
	logic out_vld_q;
	logic [cst_pkg::NCOL_W-1:0] ncols_q;
	logic [CW-1:0] ec_q, acc_q, btot_q, j_q;
	logic [cst_pkg::ROW_W-1:0] prev_q;
	logic built_q;
	logic [DW-1:0] bcols_q, i_q, nc;
	logic [MAX_DIM-1:0] cnt_vld_q;

	logic [CW-1:0] ec_eff, cnt_rd, ptr_rd, fill_rd, cnt_cur, acc_n;
	logic [cst_pkg::ROW_W-1:0] prev_eff;
	logic [cst_pkg::STATUS_W-1:0] dec_status;
	logic [SRC_W-1:0] src_rd;
	logic [DST_W-1:0] dest_rd;
	logic [cst_pkg::ROW_W-1:0] s_row;
	logic [cst_pkg::COL_W-1:0] s_col;
	logic [cst_pkg::VAL_W-1:0] s_val;
	logic col_ok, ld_ok, ld_clear;
	logic [CAW-1:0] in_col, i_col, s_col_a;

	logic cnt_we, cnt_re, ptr_we, ptr_re, fill_we, fill_re, src_we, src_re, dst_we, dst_re;
	logic [CAW-1:0] cnt_raddr, fill_waddr;
	logic [DW-1:0] ptr_waddr;
	logic [CW-1:0] ptr_wdata, fill_wdata;

	assign nc = (32'(ncols_q) > MAX_DIM) ? DW'(MAX_DIM) : DW'(ncols_q);
	assign ec_eff = built_q ? '0 : ec_q;
	assign prev_eff = built_q ? '0 : prev_q;
	assign in_col = CAW'(in_q.col);
	assign i_col = CAW'(i_q);
	assign s_row = src_rd[SRC_W-1 -: cst_pkg::ROW_W];
	assign s_col = src_rd[cst_pkg::VAL_W +: cst_pkg::COL_W];
	assign s_val = src_rd[cst_pkg::VAL_W-1:0];
	assign s_col_a = CAW'(s_col);
	assign col_ok = 32'(s_col) < 32'(nc);
	assign cnt_cur = cnt_vld_q[i_col] ? cnt_rd : '0;
	assign acc_n = acc_q + cnt_cur;

	always_comb begin
		case (in_q.func)
			cst_pkg::FUNC_LOAD: begin
				if (32'(ec_eff) >= MAX_NONZEROS) dec_status = cst_pkg::ST_FULL;
				else if (32'(in_q.col) >= 32'(nc)) dec_status = cst_pkg::ST_COL;
				else if (in_q.row < prev_eff) dec_status = cst_pkg::ST_ROW;
				else dec_status = cst_pkg::ST_OK;
			end
			cst_pkg::FUNC_RDPTR: begin
				if (!built_q || 32'(in_q.read_index) > 32'(bcols_q)) dec_status = cst_pkg::ST_BAD;
				else dec_status = cst_pkg::ST_OK;
			end
			cst_pkg::FUNC_RDENT: begin
				if (!built_q || 32'(in_q.read_index) >= 32'(btot_q)) dec_status = cst_pkg::ST_BAD;
				else dec_status = cst_pkg::ST_OK;
			end
			default: dec_status = cst_pkg::ST_OK;
		endcase
	end

	assign ld_ok = cmd.dec && (in_q.func == cst_pkg::FUNC_LOAD) && (dec_status == cst_pkg::ST_OK);
	assign ld_clear = cmd.dec && (in_q.func == cst_pkg::FUNC_LOAD) && built_q;

	always_comb begin
		sts.func = in_q.func;
		sts.dec_err = (dec_status != cst_pkg::ST_OK);
		sts.nc_zero = (nc == '0);
		sts.ec_zero = (ec_q == '0);
		sts.last_col = ((i_q + DW'(1)) == nc);
		sts.last_ent = ((j_q + CW'(1)) == ec_q);
		sts.col_ok = col_ok;
		sts.out_free = !out_vld_q || !rsp_stall;
	end

	// memory port steering
	assign src_we = ld_ok;
	assign src_re = cmd.ssrc;
	assign cnt_re = ld_ok || cmd.bcnt;
	assign cnt_raddr = cmd.bcnt ? i_col : in_col;
	assign cnt_we = cmd.ldinc;
	assign ptr_we = (cmd.dec && in_q.func == cst_pkg::FUNC_BUILD) || cmd.bacc;
	assign ptr_waddr = cmd.bacc ? (i_q + DW'(1)) : '0;
	assign ptr_wdata = cmd.bacc ? acc_n : '0;
	assign ptr_re = cmd.dec && in_q.func == cst_pkg::FUNC_RDPTR && dec_status == cst_pkg::ST_OK;
	assign fill_we = cmd.bacc || cmd.swr;
	assign fill_waddr = cmd.bacc ? i_col : s_col_a;
	assign fill_wdata = cmd.bacc ? acc_q : (fill_rd + CW'(1));
	assign fill_re = cmd.sfil && col_ok;
	assign dst_we = cmd.swr;
	assign dst_re = cmd.dec && in_q.func == cst_pkg::FUNC_RDENT && dec_status == cst_pkg::ST_OK;

	cst_ram #(.WIDTH(SRC_W), .DEPTH(MAX_NONZEROS)) u_src (
		.clk(clk), .we(src_we), .waddr(AW'(ec_eff)),
		.wdata({in_q.row, in_q.col, in_q.value}),
		.re(src_re), .raddr(AW'(j_q)), .rdata(src_rd)
	);

	cst_ram #(.WIDTH(CW), .DEPTH(MAX_DIM)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(in_col),
		.wdata((cnt_vld_q[in_col] ? cnt_rd : '0) + CW'(1)),
		.re(cnt_re), .raddr(cnt_raddr), .rdata(cnt_rd)
	);

	cst_ram #(.WIDTH(CW), .DEPTH(MAX_DIM + 1)) u_ptr (
		.clk(clk), .we(ptr_we), .waddr(ptr_waddr), .wdata(ptr_wdata),
		.re(ptr_re), .raddr(DW'(in_q.read_index)), .rdata(ptr_rd)
	);

	cst_ram #(.WIDTH(CW), .DEPTH(MAX_DIM)) u_fill (
		.clk(clk), .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
		.re(fill_re), .raddr(s_col_a), .rdata(fill_rd)
	);

	cst_ram #(.WIDTH(DST_W), .DEPTH(MAX_NONZEROS)) u_dst (
		.clk(clk), .we(dst_we), .waddr(AW'(fill_rd)), .wdata({s_row, s_val}),
		.re(dst_re), .raddr(AW'(in_q.read_index)), .rdata(dest_rd)
	);

	always_comb begin
		res_d = '0;
		res_d.status = dec_status;
	end

	// merge the read data into the pending result
	always_comb begin
		out_d = res_q;
		if (res_q.status == cst_pkg::ST_OK && in_q.func == cst_pkg::FUNC_RDPTR) begin
			out_d.out_pointer = cst_pkg::PTR_W'(ptr_rd);
		end
		if (res_q.status == cst_pkg::ST_OK && in_q.func == cst_pkg::FUNC_RDENT) begin
			out_d.out_index = dest_rd[DST_W-1 -: cst_pkg::ROW_W];
			out_d.out_value = dest_rd[cst_pkg::VAL_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= req;
		end
		if (cmd.dec) begin
			res_q <= res_d;
		end
		if (cmd.resp) begin
			out_q <= out_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ncols_q <= cst_pkg::NCOL_W'(256);
			ec_q <= '0;
			prev_q <= '0;
			built_q <= 1'b0;
			bcols_q <= '0;
			btot_q <= '0;
			acc_q <= '0;
			i_q <= '0;
			j_q <= '0;
			cnt_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ncols_q <= cfg_wdata;
			end
			if (ld_clear) begin
				cnt_vld_q <= '0;
				built_q <= 1'b0;
			end
			if (ld_ok) begin
				ec_q <= ec_eff + CW'(1);
				prev_q <= in_q.row;
			end else if (ld_clear) begin
				ec_q <= '0;
				prev_q <= '0;
			end
			if (cmd.ldinc) begin
				cnt_vld_q[in_col] <= 1'b1;
			end
			if (cmd.dec && in_q.func == cst_pkg::FUNC_BUILD) begin
				acc_q <= '0;
				i_q <= '0;
				j_q <= '0;
			end
			if (cmd.bacc) begin
				acc_q <= acc_n;
				i_q <= i_q + DW'(1);
			end
			if ((cmd.sfil && !col_ok) || cmd.swr) begin
				j_q <= j_q + CW'(1);
			end
			if (cmd.bfin) begin
				built_q <= 1'b1;
				bcols_q <= nc;
				btot_q <= acc_q;
			end
			if (cmd.resp) begin
				out_vld_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_vld_q;
	assign rsp = out_q;

endmodule
